// ----- src/tevq_pkg.sv -----
package tevq_pkg;

   localparam int DEFAULT_DEPTH = 32;
   localparam int MAX_FIRE = 32;
   localparam int TIME_W = 32;
   localparam int ID_W = 16;
   localparam int COUNT_OUT_W = 6;

   localparam logic [1:0] REQ_ADD = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_ADVANCE = 2'd2;

   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_FIRE = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_PAST = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_POP
   } cell_op_type;

   typedef struct packed {
      logic [TIME_W-1:0] due_time;
      logic [ID_W-1:0]   id;
   } entry_type;

   typedef struct packed {
      cell_op_type       op;
      logic [TIME_W-1:0] key;
      entry_type         item;
   } cell_cmd_type;

endpackage

// ----- src/tevq_req_if.sv -----
interface tevq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] time_value;
   logic [15:0] event_id;

   modport source (output valid, output req_type, output time_value, output event_id,
                   input ready);
   modport sink (input valid, input req_type, input time_value, input event_id,
                 output ready);
endinterface

// ----- src/tevq_rsp_if.sv -----
interface tevq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  res_kind;
   logic [1:0]  status;
   logic [15:0] fired_id;
   logic [31:0] fired_time;
   logic [5:0]  removed_count;
   logic        last;

   modport source (output valid, output res_kind, output status, output fired_id,
                   output fired_time, output removed_count, output last, input ready);
   modport sink (input valid, input res_kind, input status, input fired_id,
                 input fired_time, input removed_count, input last, output ready);
endinterface

// ----- src/tevq_cell.sv -----
module tevq_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 6
) (
   input  logic                  clock,
   input  tevq_pkg::cell_cmd_type cmd,
   input  logic [CNT_W-1:0]      count,
   input  tevq_pkg::entry_type   left_entry,
   input  tevq_pkg::entry_type   right_entry,
   input  logic                  keep_in,
   input  logic                  seen_in,
   output tevq_pkg::entry_type   entry,
   output logic                  keep_out,
   output logic                  seen_out
);
   import tevq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      occupied;

   assign occupied = CNT_W'(INDEX) < count;
   assign keep_out = occupied && (entry_ff.due_time <= cmd.key);
   assign seen_out = seen_in || (occupied && (entry_ff.due_time == cmd.key));
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.op)
         CELL_INSERT: begin
            if (!keep_out) begin
               entry_in = keep_in ? cmd.item : left_entry;
            end
         end
         CELL_DELETE: begin
            if (seen_out) begin
               entry_in = right_entry;
            end
         end
         CELL_POP: entry_in = right_entry;
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- src/timed_event_queue.sv -----
// Sorted timed event queue.
// The req channel takes one request per transfer: add an event (due time and
// handle), remove every event at a time, or advance the current time by a delta.
// Results leave on the rsp channel through a single output register.
// An add gives one acknowledge with its status in the cycle after its transfer.
// A remove deletes one matching entry per cycle, then gives its acknowledge
// with the count once no matching entry is left.
// An advance updates the time, then fires one due event per cycle while the receiver
// takes results, earliest first, flagging the last; an advance with nothing due gives no result.
// The table is a row of cells that shift toward or away from the head, so a new
// request is taken only once the previous one has finished its walk.
// A request with an unknown type is taken and gives nothing.
// Reset empties the table and sets the current time to zero.
// When the receiver stalls, the pending result is held and no further result is made; a
// new request is taken while a result waits only if that result is transferred
// in the same cycle.
module timed_event_queue #(
   parameter int QUEUE_DEPTH = tevq_pkg::DEFAULT_DEPTH
) (
   input logic       clock,
   input logic       reset,
   tevq_req_if.sink  req,
   tevq_rsp_if.source rsp
);
   import tevq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int FIRE_W = $clog2(MAX_FIRE + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_FIRE
   } state_type;

   state_type           state_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [TIME_W-1:0]   key_ff;
   logic [CNT_W-1:0]    removed_ff;
   logic [FIRE_W-1:0]   fired_ff;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [1:0]          res_kind_ff;
   logic [1:0]          status_ff;
   logic [ID_W-1:0]     fired_id_ff;
   logic [TIME_W-1:0]   fired_time_ff;
   logic [COUNT_OUT_W-1:0] removed_count_ff;
   logic                last_ff;

   entry_type           cells [QUEUE_DEPTH];
   logic                keep [QUEUE_DEPTH+1];
   logic                seen [QUEUE_DEPTH+1];
   cell_cmd_type        cmd;

   logic                out_free;
   logic                accept;
   logic [1:0]          add_status;
   logic                any_match;
   logic                due;
   logic                next_due;
   logic [TIME_W:0]     adv_sum;
   logic [TIME_W-1:0]   adv_time;

   assign keep[0] = 1'b1;
   assign seen[0] = 1'b0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      if (i == 0) begin : g_head
         assign left_entry = cells[i];
      end else begin : g_body
         assign left_entry = cells[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_entry = cells[i];
      end else begin : g_inner
         assign right_entry = cells[i+1];
      end
      tevq_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .keep_in     (keep[i]),
         .seen_in     (seen[i]),
         .entry       (cells[i]),
         .keep_out    (keep[i+1]),
         .seen_out    (seen[i+1])
      );
   end

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && out_free;
   assign accept = req.valid && req.ready;
   assign any_match = seen[QUEUE_DEPTH];

   assign adv_sum = {1'b0, now_ff} + {1'b0, req.time_value};
   assign adv_time = adv_sum[TIME_W] ? {TIME_W{1'b1}} : adv_sum[TIME_W-1:0];

   assign due = (count_ff != '0) && (cells[0].due_time <= now_ff)
                && (fired_ff != FIRE_W'(MAX_FIRE));
   assign next_due = (count_ff > CNT_W'(1)) && (cells[1].due_time <= now_ff);

   assign rsp_valid_in = ((state_ff == ST_IDLE) && accept && (req.req_type == REQ_ADD))
                         || ((state_ff == ST_REMOVE) && !any_match && out_free)
                         || ((state_ff == ST_FIRE) && due && out_free)
                         || (rsp_valid_ff && !rsp.ready);

   always_comb begin
      if (req.time_value < now_ff) begin
         add_status = STATUS_PAST;
      end else if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
         add_status = STATUS_FULL;
      end else begin
         add_status = STATUS_OK;
      end
   end

   always_comb begin
      cmd.op = CELL_HOLD;
      cmd.key = key_ff;
      cmd.item.due_time = req.time_value;
      cmd.item.id = req.event_id;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.key = req.time_value;
            if (accept && (req.req_type == REQ_ADD) && (add_status == STATUS_OK)) begin
               cmd.op = CELL_INSERT;
            end
         end
         ST_REMOVE: begin
            if (any_match) begin
               cmd.op = CELL_DELETE;
            end
         end
         ST_FIRE: begin
            if (due && out_free) begin
               cmd.op = CELL_POP;
            end
         end
         default: cmd.op = CELL_HOLD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         now_ff <= '0;
         removed_ff <= '0;
         fired_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req.req_type)
                     REQ_ADD: begin
                        res_kind_ff <= KIND_ADD;
                        status_ff <= add_status;
                        fired_id_ff <= '0;
                        fired_time_ff <= '0;
                        removed_count_ff <= '0;
                        last_ff <= 1'b1;
                        if (add_status == STATUS_OK) begin
                           count_ff <= count_ff + CNT_W'(1);
                        end
                     end
                     REQ_REMOVE: begin
                        key_ff <= req.time_value;
                        removed_ff <= '0;
                        state_ff <= ST_REMOVE;
                     end
                     REQ_ADVANCE: begin
                        now_ff <= adv_time;
                        fired_ff <= '0;
                        state_ff <= ST_FIRE;
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_REMOVE: begin
               if (any_match) begin
                  count_ff <= count_ff - CNT_W'(1);
                  removed_ff <= removed_ff + CNT_W'(1);
               end else if (out_free) begin
                  res_kind_ff <= KIND_REMOVE;
                  status_ff <= STATUS_OK;
                  fired_id_ff <= '0;
                  fired_time_ff <= '0;
                  removed_count_ff <= COUNT_OUT_W'(removed_ff);
                  last_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            ST_FIRE: begin
               if (!due) begin
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  res_kind_ff <= KIND_FIRE;
                  status_ff <= STATUS_OK;
                  fired_id_ff <= cells[0].id;
                  fired_time_ff <= cells[0].due_time;
                  removed_count_ff <= '0;
                  last_ff <= (fired_ff == FIRE_W'(MAX_FIRE - 1)) || !next_due;
                  count_ff <= count_ff - CNT_W'(1);
                  fired_ff <= fired_ff + FIRE_W'(1);
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.res_kind = res_kind_ff;
   assign rsp.status = status_ff;
   assign rsp.fired_id = fired_id_ff;
   assign rsp.fired_time = fired_time_ff;
   assign rsp.removed_count = removed_count_ff;
   assign rsp.last = last_ff;

endmodule

// ----- tb/timed_event_queue_tb.sv -----
module timed_event_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tevq_pkg::*;

   localparam int DEPTH = DEFAULT_DEPTH;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int RANDOM_ITEMS = 250;
   localparam int LONG_STALL = 300;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [1:0]             kind;
      logic [1:0]             status;
      logic [ID_W-1:0]        id;
      logic [TIME_W-1:0]      due;
      logic [COUNT_OUT_W-1:0] removed;
      logic                   last;
   } event_result_type;

   class event_table_scoreboard_type;
      logic [TIME_W-1:0] due_time [DEPTH];
      logic [ID_W-1:0]   handle [DEPTH];
      int                pending_events;
      logic [TIME_W-1:0] now_time;
      event_result_type  awaited[$];
      int                mismatches;

      function new();
         pending_events = 0;
         now_time = '0;
         mismatches = 0;
      endfunction

      function void note_request(logic [1:0] kind, logic [TIME_W-1:0] tv,
                                 logic [ID_W-1:0] id);
         event_result_type r;
         int pos;
         int kept;
         int fired;
         logic [TIME_W:0] sum;
         r = '0;
         r.last = 1'b1;
         case (kind)
            REQ_ADD: begin
               r.kind = KIND_ADD;
               if (tv < now_time) begin
                  r.status = STATUS_PAST;
               end else if (pending_events >= DEPTH) begin
                  r.status = STATUS_FULL;
               end else begin
                  r.status = STATUS_OK;
                  pos = 0;
                  while (pos < pending_events && due_time[pos] <= tv) pos++;
                  for (int i = pending_events; i > pos; i--) begin
                     due_time[i] = due_time[i-1];
                     handle[i] = handle[i-1];
                  end
                  due_time[pos] = tv;
                  handle[pos] = id;
                  pending_events++;
               end
               awaited.insert(awaited.size(), r);
            end
            REQ_REMOVE: begin
               kept = 0;
               for (int i = 0; i < pending_events; i++) begin
                  if (due_time[i] != tv) begin
                     due_time[kept] = due_time[i];
                     handle[kept] = handle[i];
                     kept++;
                  end
               end
               r.kind = KIND_REMOVE;
               r.removed = COUNT_OUT_W'(pending_events - kept);
               pending_events = kept;
               awaited.insert(awaited.size(), r);
            end
            REQ_ADVANCE: begin
               sum = {1'b0, now_time} + {1'b0, tv};
               now_time = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
               fired = 0;
               while (fired < pending_events && fired < MAX_FIRE
                      && due_time[fired] <= now_time) fired++;
               for (int i = 0; i < fired; i++) begin
                  r = '0;
                  r.kind = KIND_FIRE;
                  r.id = handle[i];
                  r.due = due_time[i];
                  r.last = (i == fired - 1);
                  awaited.insert(awaited.size(), r);
               end
               for (int i = fired; i < pending_events; i++) begin
                  due_time[i-fired] = due_time[i];
                  handle[i-fired] = handle[i];
               end
               pending_events -= fired;
            end
            default: ;
         endcase
      endfunction

      function void note_mismatch(string why, event_result_type want,
                                  event_result_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t mismatch (%s): expected kind=%0d status=%0d id=%h",
                     $realtime, why, want.kind, want.status, want.id,
                     " time=%h count=%0d last=%0b", want.due, want.removed, want.last);
            $display("%0t            actual   kind=%0d status=%0d id=%h",
                     $realtime, got.kind, got.status, got.id,
                     " time=%h count=%0d last=%0b", got.due, got.removed, got.last);
         end
      endfunction

      function void check_result(event_result_type got);
         event_result_type want;
         if (awaited.size() == 0) begin
            note_mismatch("no result was due", '0, got);
         end else begin
            want = awaited.pop_front();
            if (got.kind !== want.kind || got.status !== want.status || got.id !== want.id
                || got.due !== want.due || got.removed !== want.removed
                || got.last !== want.last)
               note_mismatch("wrong field", want, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   tevq_req_if req_bus ();
   tevq_rsp_if rsp_bus ();

   event_table_scoreboard_type sb;
   int   cycle_count = 0;
   int   items_sent = 0;
   logic steady = 1'b0;
   int   stall_asks = 0;
   int   stall_done = 0;
   int   stall_left = 0;
   int   ready_left = 0;
   int   ready_pick;

   timed_event_queue #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .rsp(rsp_bus)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL timed_event_queue");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result({rsp_bus.res_kind, rsp_bus.status, rsp_bus.fired_id,
                             rsp_bus.fired_time, rsp_bus.removed_count, rsp_bus.last});
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.req_type, req_bus.time_value, req_bus.event_id);
      end
   end

   // The receiver runs its own random ready pattern and, on request, holds off
   // for a long stretch so that the table backs up into the request channel.
   always @(negedge clock) begin
      if (stall_asks != stall_done) begin
         stall_done = stall_asks;
         stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
         rsp_bus.ready = 1'b0;
         stall_left--;
      end else if (steady) begin
         rsp_bus.ready = 1'b1;
      end else if (ready_left > 0) begin
         ready_left--;
      end else begin
         ready_pick = $urandom_range(0, 99);
         if (ready_pick < 65) begin
            rsp_bus.ready = 1'b1;
            ready_left = $urandom_range(0, 6);
         end else if (ready_pick < 92) begin
            rsp_bus.ready = 1'b0;
            ready_left = $urandom_range(0, 2);
         end else begin
            rsp_bus.ready = 1'b0;
            ready_left = $urandom_range(9, 40);
         end
      end
   end

   task automatic send_request(input logic [1:0] kind, input logic [TIME_W-1:0] tv,
                               input logic [ID_W-1:0] id);
      int pick;
      int gap;
      pick = $urandom_range(0, 99);
      if (steady || pick < 60) gap = 0;
      else if (pick < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      req_bus.valid = 1'b0;
      repeat (gap) @(negedge clock);
      req_bus.req_type = kind;
      req_bus.time_value = tv;
      req_bus.event_id = id;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      req_bus.valid = 1'b0;
      items_sent++;
   endtask

   task automatic wait_drain();
      req_bus.valid = 1'b0;
      while (sb.awaited.size() != 0) @(negedge clock);
   endtask

   task automatic send_random_item();
      int pick;
      int sub;
      logic [1:0] kind;
      logic [TIME_W-1:0] tv;
      pick = $urandom_range(0, 99);
      sub = $urandom_range(0, 19);
      if (pick < 45) begin
         kind = REQ_ADD;
         if (sub < 16) tv = sb.now_time + $urandom_range(0, 120);
         else if (sub < 19) tv = (sb.now_time > 50) ? sb.now_time - $urandom_range(1, 50)
                                                    : sb.now_time;
         else tv = $urandom;
      end else if (pick < 65) begin
         kind = REQ_REMOVE;
         if (sb.pending_events > 0 && sub < 14)
            tv = sb.due_time[$urandom_range(0, sb.pending_events - 1)];
         else if (sub < 18) tv = sb.now_time + $urandom_range(0, 120);
         else tv = $urandom;
      end else if (pick < 95) begin
         kind = REQ_ADVANCE;
         tv = (sub < 2) ? '0 : TIME_W'($urandom_range(1, 60));
      end else begin
         kind = REQ_UNKNOWN;
         tv = $urandom;
      end
      send_request(kind, tv, ID_W'($urandom));
   endtask

   task automatic fill_table();
      int needed;
      needed = DEPTH - sb.pending_events + 2;
      repeat (needed) send_request(REQ_ADD, sb.now_time + $urandom_range(0, 40),
                                   ID_W'($urandom));
      send_request(REQ_ADVANCE, TIME_W'(50), ID_W'($urandom));
   endtask

   initial begin
      int phase;
      sb = new();
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.req_type = REQ_ADD;
      req_bus.time_value = '0;
      req_bus.event_id = '0;
      rsp_bus.ready = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed cases: several adds share a due time, and one remove takes them all out.
      send_request(REQ_ADD, 32'd0, 16'h0000);
      send_request(REQ_ADD, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(REQ_ADD, 32'd20, 16'h1234);
      send_request(REQ_ADD, 32'd20, 16'h0001);
      send_request(REQ_ADD, 32'd7, 16'h8000);
      send_request(REQ_ADD, 32'd20, 16'h0002);
      send_request(REQ_REMOVE, 32'd20, 16'h0000);
      send_request(REQ_REMOVE, 32'd21, 16'h0000);
      send_request(REQ_UNKNOWN, 32'h5A5A_5A5A, 16'hA5A5);
      send_request(REQ_ADVANCE, 32'd0, 16'h0000);
      send_request(REQ_ADD, 32'd9, 16'h00FF);
      send_request(REQ_ADD, 32'd12, 16'hFF00);
      send_request(REQ_ADVANCE, 32'd10, 16'h0000);
      send_request(REQ_ADD, 32'd3, 16'h7777);
      send_request(REQ_ADVANCE, 32'd1, 16'h0000);
      send_request(REQ_ADVANCE, 32'd1, 16'h0000);
      send_request(REQ_REMOVE, 32'hFFFF_FFFF, 16'h0000);
      send_request(REQ_REMOVE, 32'd0, 16'h0000);
      wait_drain();

      stall_asks++;
      fill_table();
      wait_drain();

      while (items_sent < RANDOM_ITEMS) begin
         phase = $urandom_range(0, 9);
         if (phase == 0) begin
            fill_table();
         end else begin
            steady = (phase == 1);
            repeat ($urandom_range(10, 30)) send_random_item();
            steady = 1'b0;
         end
         if ($urandom_range(0, 3) == 0) wait_drain();
      end

      // Saturating advances pin the current time at its maximum, so they come last.
      send_request(REQ_ADD, 32'hFFFF_FFFF, 16'h5AA5);
      send_request(REQ_ADD, sb.now_time + 3, 16'hC3C3);
      send_request(REQ_ADVANCE, 32'hFFFF_FFFF, 16'h0000);
      send_request(REQ_ADD, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(REQ_ADD, 32'd5, 16'h0F0F);
      send_request(REQ_ADVANCE, 32'd7, 16'h0000);
      wait_drain();
      repeat (100) @(negedge clock);

      if (sb.awaited.size() != 0) sb.note_mismatch("result never arrived", sb.awaited[0], '0);
      if (sb.mismatches == 0) begin
         $display("PASS timed_event_queue");
      end else begin
         $display("FAIL timed_event_queue");
      end
      $finish;
   end
endmodule
